>>> src/vrt_pkg.sv
package vrt_pkg;

    localparam int MAX_VOXELS_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ORIGIN_W       = 32;
    localparam int DIR_W          = 16;
    localparam int LEN_W          = 22;
    localparam int COORD_W        = 16;
    localparam int ENTRY_W        = 22;
    localparam int LIMIT_W        = 7;
    localparam int MAG_W          = 17;
    localparam logic [LEN_W-1:0]   LEN_ZERO    = '0;
    localparam logic [ENTRY_W-1:0] ENTRY_MAX   = 22'd2228224;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    typedef struct packed {
        logic signed [ORIGIN_W-1:0] origin_x;
        logic signed [ORIGIN_W-1:0] origin_y;
        logic signed [ORIGIN_W-1:0] origin_z;
        logic signed [DIR_W-1:0]    dir_x;
        logic signed [DIR_W-1:0]    dir_y;
        logic signed [DIR_W-1:0]    dir_z;
        logic [LEN_W-1:0]           ray_length;
    } ray_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] voxel_x;
        logic signed [COORD_W-1:0] voxel_y;
        logic signed [COORD_W-1:0] voxel_z;
        logic [ENTRY_W-1:0]        entry_distance;
        logic                      last_voxel;
        logic                      truncated;
    } voxel_t;

    typedef struct packed {
        logic load;
        logic square;
        logic root_step;
        logic div_first;
        logic div_step;
        logic mul;
        logic walk;
    } cmd_t;

    typedef struct packed {
        logic emit_ok;
        logic last;
    } status_t;

endpackage

>>> src/vrt_ifs.sv
interface vrt_ray_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   origin_x;
    logic signed [31:0]   origin_y;
    logic signed [31:0]   origin_z;
    logic signed [15:0]   dir_x;
    logic signed [15:0]   dir_y;
    logic signed [15:0]   dir_z;
    logic [21:0]          ray_length;
    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    ray_length, input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  ray_length, output ready);
endinterface

interface vrt_voxel_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   voxel_x;
    logic signed [15:0]   voxel_y;
    logic signed [15:0]   voxel_z;
    logic [21:0]          entry_distance;
    logic                 last_voxel;
    logic                 truncated;
    modport source (output valid, voxel_x, voxel_y, voxel_z, entry_distance, last_voxel,
                    truncated, input ready);
    modport sink (input valid, voxel_x, voxel_y, voxel_z, entry_distance, last_voxel,
                  truncated, output ready);
endinterface

interface vrt_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] voxel_limit;
    modport source (output valid, voxel_limit, input ready);
    modport sink (input valid, voxel_limit, output ready);
endinterface

>>> src/vrt_ctrl.sv
module vrt_ctrl #(
    parameter int FRAC_BITS = vrt_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  vrt_pkg::status_t status,
    output vrt_pkg::cmd_t    cmd
);
    import vrt_pkg::*;

    localparam int RW = 16 + FRAC_BITS;
    localparam int SW = $clog2(RW);
    localparam logic [SW-1:0] LAST_STEP = SW'(RW - 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SQR  = 6'b000010,
        ST_ROOT = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_WALK = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    logic [SW-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                cmd.square = 1'b1;
                cnt_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (cnt_reg == '0);
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (status.emit_ok)
                begin
                    cmd.walk = 1'b1;
                    if (status.last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/vrt_dp.sv
module vrt_dp #(
    parameter int MAX_VOXELS = vrt_pkg::MAX_VOXELS_DEF,
    parameter int FRAC_BITS  = vrt_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  vrt_pkg::cmd_t     cmd,
    output vrt_pkg::status_t  status,
    input  vrt_pkg::ray_t     ray_in,
    input  logic              cfg_we,
    input  logic [6:0]        cfg_data,
    output vrt_pkg::voxel_t   out_word,
    output logic              out_valid,
    input  logic              out_ready
);
    import vrt_pkg::*;

    localparam int RW = 16 + FRAC_BITS;
    localparam int XW = 2 * RW;
    localparam int TW = FRAC_BITS + 24;
    localparam int EW = TW + 16;
    localparam int CW = $clog2(MAX_VOXELS + 1);
    localparam int PW = MAG_W + RW;
    localparam logic [LIMIT_W-1:0] LIM_MAX = LIMIT_W'(MAX_VOXELS);

    logic [LIMIT_W-1:0]  limit_reg;
    logic [MAG_W-1:0]    mag_reg [3];
    logic                pos_reg [3];
    logic [15:0]         fr_reg [3];
    logic [COORD_W-1:0]  coord_reg [3];
    logic [LEN_W-1:0]    len_reg;
    logic [XW-1:0]       rad_reg;
    logic [RW-1:0]       root_reg;
    logic [RW+1:0]       rem_reg;
    logic [RW-1:0]       dq_reg [3];
    logic [MAG_W-1:0]    dr_reg [3];
    logic [TW-1:0]       tn_reg [3];
    logic [TW-1:0]       delta_reg [3];
    logic [TW-1:0]       t_reg;
    logic [CW-1:0]       count_reg;
    logic                out_valid_reg;
    voxel_t              out_reg;

    logic                mv [3];
    logic [MAG_W-1:0]    mag_in [3];
    logic                pos_in [3];
    logic signed [DIR_W-1:0] dir_in [3];
    logic [ORIGIN_W-1:0] org_in [3];
    logic [33:0]         ssum;
    logic [RW+3:0]       rsh, rtrial;
    logic [RW-1:0]       dsrc [3];
    logic [MAG_W:0]      dsh [3];
    logic                earl01, earl02, earl12;
    logic [1:0]          ax;
    logic                stuck, reached, at_cap, last;
    logic [EW-1:0]       t_sh, e_full;
    logic [ENTRY_W-1:0]  entry;
    logic [CW-1:0]       lim;
    logic [TW-1:0]       t_ax, d_ax;
    logic                mv_ax, pos_ax;

    assign org_in[0] = ray_in.origin_x;
    assign org_in[1] = ray_in.origin_y;
    assign org_in[2] = ray_in.origin_z;
    assign dir_in[0] = ray_in.dir_x;
    assign dir_in[1] = ray_in.dir_y;
    assign dir_in[2] = ray_in.dir_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_in[i] = dir_in[i][DIR_W-1] ? MAG_W'(17'h10000 - {1'b0, dir_in[i]})
                                            : {1'b0, dir_in[i]};
            pos_in[i] = !dir_in[i][DIR_W-1] && (dir_in[i] != '0);
            mv[i]     = (mag_reg[i] != '0);
            dsrc[i]   = cmd.div_first ? root_reg : dq_reg[i];
            dsh[i]    = {(cmd.div_first ? '0 : dr_reg[i]), dsrc[i][RW-1]};
        end
    end

    assign ssum = 34'(mag_reg[0] * mag_reg[0]) + 34'(mag_reg[1] * mag_reg[1])
                + 34'(mag_reg[2] * mag_reg[2]);
    assign rsh    = {rem_reg, rad_reg[XW-1:XW-2]};
    assign rtrial = (RW+4)'({root_reg, 2'b01});

    // axis choice, x wins only when strictly earliest
    assign earl01 = mv[0] && (!mv[1] || tn_reg[0] < tn_reg[1]);
    assign earl02 = mv[0] && (!mv[2] || tn_reg[0] < tn_reg[2]);
    assign earl12 = mv[1] && (!mv[2] || tn_reg[1] < tn_reg[2]);
    assign ax     = (earl01 && earl02) ? 2'd0 : (earl12 ? 2'd1 : 2'd2);

    always_comb
    begin
        unique case (ax)
            2'd0:
            begin
                t_ax = tn_reg[0]; d_ax = delta_reg[0]; mv_ax = mv[0]; pos_ax = pos_reg[0];
            end
            2'd1:
            begin
                t_ax = tn_reg[1]; d_ax = delta_reg[1]; mv_ax = mv[1]; pos_ax = pos_reg[1];
            end
            default:
            begin
                t_ax = tn_reg[2]; d_ax = delta_reg[2]; mv_ax = mv[2]; pos_ax = pos_reg[2];
            end
        endcase
    end

    always_comb
    begin
        priority if (limit_reg == '0)
            lim = CW'(1);
        else if (limit_reg > LIM_MAX)
            lim = CW'(MAX_VOXELS);
        else
            lim = CW'(limit_reg);
    end

    assign t_sh    = {t_reg, 16'b0};
    assign reached = t_sh >= EW'({len_reg, {FRAC_BITS{1'b0}}});
    assign stuck   = !mv_ax;
    assign at_cap  = ({1'b0, count_reg} + 1'b1) >= {1'b0, lim};
    assign last    = reached || stuck || at_cap;
    assign e_full  = t_sh >> FRAC_BITS;
    assign entry   = (e_full > EW'(ENTRY_MAX)) ? ENTRY_MAX : e_full[ENTRY_W-1:0];

    assign status.emit_ok = !out_valid_reg || out_ready;
    assign status.last    = last;
    assign out_valid      = out_valid_reg;
    assign out_word       = out_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_data;
            if (cmd.walk)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i]   <= mag_in[i];
                pos_reg[i]   <= pos_in[i];
                fr_reg[i]    <= org_in[i][15:0];
                coord_reg[i] <= org_in[i][31:16];
            end
            len_reg <= ray_in.ray_length;
        end
        if (cmd.square)
        begin
            rad_reg  <= {ssum[31:0], {(2*FRAC_BITS){1'b0}}};
            root_reg <= '0;
            rem_reg  <= '0;
        end
        if (cmd.root_step)
        begin
            rad_reg <= {rad_reg[XW-3:0], 2'b00};
            if (rsh >= rtrial)
            begin
                rem_reg  <= (RW+2)'(rsh - rtrial);
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rsh[RW+1:0];
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
        if (cmd.div_step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (dsh[i] >= {1'b0, mag_reg[i]})
                begin
                    dr_reg[i] <= MAG_W'(dsh[i] - {1'b0, mag_reg[i]});
                    dq_reg[i] <= {dsrc[i][RW-2:0], 1'b1};
                end
                else
                begin
                    dr_reg[i] <= dsh[i][MAG_W-1:0];
                    dq_reg[i] <= {dsrc[i][RW-2:0], 1'b0};
                end
            end
        end
        if (cmd.mul)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (mv[i])
                begin
                    tn_reg[i] <= TW'(PW'((pos_reg[i] ? MAG_W'(17'h10000 - {1'b0, fr_reg[i]})
                                                     : {1'b0, fr_reg[i]}) * dq_reg[i]) >> 16);
                    delta_reg[i] <= TW'(dq_reg[i]);
                end
                else
                begin
                    tn_reg[i]    <= '0;
                    delta_reg[i] <= '0;
                end
            end
            t_reg     <= '0;
            count_reg <= '0;
        end
        if (cmd.walk)
        begin
            out_reg.voxel_x        <= coord_reg[0];
            out_reg.voxel_y        <= coord_reg[1];
            out_reg.voxel_z        <= coord_reg[2];
            out_reg.entry_distance <= entry;
            out_reg.last_voxel     <= last;
            out_reg.truncated      <= !reached && !stuck && at_cap;
            if (!last)
            begin
                t_reg         <= t_ax;
                tn_reg[ax]    <= t_ax + d_ax;
                coord_reg[ax] <= pos_ax ? coord_reg[ax] + 1'b1 : coord_reg[ax] - 1'b1;
                count_reg     <= count_reg + 1'b1;
            end
        end
    end

endmodule

>>> src/voxel_ray_traversal_top.sv
// after a ray word: square, root, divide and multiply states, then the first voxel word
// then one voxel word per cycle unless stalled, up to voxel_limit (1..MAX_VOXELS) per ray
// setup time is set by the bit-serial square root and the three bit-serial dividers
// one ray at a time: next ray taken once the last voxel word is registered
// rst_n asynchronous active low: controller idle, output empty, voxel_limit back to 64
module voxel_ray_traversal_top #(
    parameter int MAX_VOXELS = vrt_pkg::MAX_VOXELS_DEF,
    parameter int FRAC_BITS  = vrt_pkg::FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    vrt_ray_if.sink    ray,
    vrt_voxel_if.source voxel,
    vrt_cfg_if.sink    cfg
);
    import vrt_pkg::*;

    cmd_t    cmd;
    status_t status;
    ray_t    ray_word;
    voxel_t  vox_word;
    logic    in_ready;

    assign ray_word.origin_x   = ray.origin_x;
    assign ray_word.origin_y   = ray.origin_y;
    assign ray_word.origin_z   = ray.origin_z;
    assign ray_word.dir_x      = ray.dir_x;
    assign ray_word.dir_y      = ray.dir_y;
    assign ray_word.dir_z      = ray.dir_z;
    assign ray_word.ray_length = ray.ray_length;
    assign ray.ready           = in_ready;
    assign cfg.ready           = 1'b1;

    assign voxel.voxel_x        = vox_word.voxel_x;
    assign voxel.voxel_y        = vox_word.voxel_y;
    assign voxel.voxel_z        = vox_word.voxel_z;
    assign voxel.entry_distance = vox_word.entry_distance;
    assign voxel.last_voxel     = vox_word.last_voxel;
    assign voxel.truncated      = vox_word.truncated;

    vrt_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (ray.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    vrt_dp #(
        .MAX_VOXELS (MAX_VOXELS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .ray_in    (ray_word),
        .cfg_we    (cfg.valid),
        .cfg_data  (cfg.voxel_limit),
        .out_word  (vox_word),
        .out_valid (voxel.valid),
        .out_ready (voxel.ready)
    );

`ifndef SYNTHESIS
    a_one_ray: assert property (@(posedge clk) disable iff (!rst_n)
        ray.valid && ray.ready |=> !ray.ready)
        else $error("ray taken while busy");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        voxel.valid && voxel.ready && voxel.last_voxel |=> !voxel.valid)
        else $error("voxel word right after last");

    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        voxel.valid && voxel.truncated |-> voxel.last_voxel)
        else $error("truncated without last");
`endif

endmodule

>>> test/tb_voxel_ray_traversal_top.sv
`timescale 1ns / 1ps

module tb_voxel_ray_traversal_top;
    import vrt_pkg::*;

    localparam int SETTLE_CYCLES = 100;

    logic clk;
    logic rst_n;

    vrt_ray_if   ray ();
    vrt_voxel_if voxel ();
    vrt_cfg_if   cfg ();

    voxel_ray_traversal_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .ray   (ray.sink),
        .voxel (voxel.source),
        .cfg   (cfg.sink)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    ray_t   pending_rays[$];
    voxel_t expected_voxels[$];
    logic [LIMIT_W-1:0] limit_shadow;
    int  error_count;
    int  ray_count;
    int  voxel_count;
    int  trunc_count;
    bit  drive_noise;
    bit  hold_sink;
    bit  hold_source;
    int  ray_gap;
    int  voxel_gap;
    int  ray_gap_pending;

    // exact floor(sqrt(s * 2^32))
    function automatic longint unsigned scaled_sqrt(longint unsigned s);
        logic [127:0] x;
        logic [127:0] res;
        logic [127:0] cand;
        x = {64'd0, s} << 32;
        res = '0;
        for (int b = 48; b >= 0; b--)
        begin
            cand = res | (128'd1 << b);
            if (cand * cand <= x)
                res = cand;
        end
        return res[63:0];
    endfunction

    task automatic trace_ray(input ray_t r);
        longint unsigned mag[3];
        longint unsigned dl[3];
        longint unsigned tn[3];
        logic [15:0] crd[3];
        bit mv[3];
        bit pos[3];
        logic [15:0] d;
        logic [31:0] o;
        longint unsigned s;
        longint unsigned root;
        longint unsigned t;
        longint unsigned m;
        longint unsigned e;
        longint unsigned lim;
        int cnt;
        int ax;
        bit reached;
        bit stuck;
        bit at_cap;
        bit done;
        voxel_t v;
        s = 0;
        t = 0;
        cnt = 0;
        done = 0;
        lim = (limit_shadow == 0) ? 1 : (limit_shadow > 64 ? 64 : limit_shadow);
        for (int i = 0; i < 3; i++)
        begin
            d = (i == 0) ? r.dir_x : (i == 1) ? r.dir_y : r.dir_z;
            o = (i == 0) ? r.origin_x : (i == 1) ? r.origin_y : r.origin_z;
            mag[i] = d[15] ? 64'h10000 - d : d;
            mv[i] = mag[i] != 0;
            pos[i] = !d[15] && d != 0;
            s += mag[i] * mag[i];
            crd[i] = o[31:16];
        end
        root = (s != 0) ? scaled_sqrt(s) : 0;
        for (int i = 0; i < 3; i++)
        begin
            o = (i == 0) ? r.origin_x : (i == 1) ? r.origin_y : r.origin_z;
            dl[i] = 0;
            tn[i] = 0;
            if (mv[i])
            begin
                m = pos[i] ? 64'h10000 - o[15:0] : o[15:0];
                dl[i] = root / mag[i];
                tn[i] = (m * dl[i]) >> 16;
            end
        end
        while (!done)
        begin
            reached = t >= r.ray_length;
            if (mv[0] && (!mv[1] || tn[0] < tn[1]) && (!mv[2] || tn[0] < tn[2]))
                ax = 0;
            else if (mv[1] && (!mv[2] || tn[1] < tn[2]))
                ax = 1;
            else
                ax = 2;
            stuck = !mv[ax];
            at_cap = (cnt + 1) >= lim;
            done = reached || stuck || at_cap;
            e = (t > ENTRY_MAX) ? ENTRY_MAX : t;
            v.voxel_x = crd[0];
            v.voxel_y = crd[1];
            v.voxel_z = crd[2];
            v.entry_distance = e[ENTRY_W-1:0];
            v.last_voxel = done;
            v.truncated = !reached && !stuck && at_cap;
            expected_voxels = {expected_voxels, v};
            cnt++;
            if (!done)
            begin
                t = tn[ax];
                tn[ax] += dl[ax];
                crd[ax] = pos[ax] ? crd[ax] + 16'd1 : crd[ax] - 16'd1;
            end
        end
    endtask

    task automatic enqueue_ray(input ray_t r);
        pending_rays = {pending_rays, r};
    endtask

    // ray driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray.valid <= 1'b0;
            ray_gap_pending <= 0;
        end
        else
        begin
            if (ray.valid && ray.ready)
            begin
                trace_ray(pending_rays.pop_front());
                ray_count++;
            end
            if (ray.valid && !ray.ready)
                ray.valid <= 1'b1;
            else if (ray_gap_pending > 0)
            begin
                ray.valid <= 1'b0;
                ray_gap_pending <= ray_gap_pending - 1;
            end
            else if (pending_rays.size() > (ray.valid && ray.ready ? 0 : 0) && !hold_source)
            begin
                if (ray_gap > 0 && $urandom_range(0, 5) == 0)
                begin
                    ray.valid <= 1'b0;
                    ray_gap_pending <= $urandom_range(1, 19);
                end
                else
                begin
                    ray.valid <= 1'b1;
                    ray.origin_x <= pending_rays[0].origin_x;
                    ray.origin_y <= pending_rays[0].origin_y;
                    ray.origin_z <= pending_rays[0].origin_z;
                    ray.dir_x <= pending_rays[0].dir_x;
                    ray.dir_y <= pending_rays[0].dir_y;
                    ray.dir_z <= pending_rays[0].dir_z;
                    ray.ray_length <= pending_rays[0].ray_length;
                end
            end
            else
                ray.valid <= 1'b0;
        end
    end

    // voxel monitor
    always @(posedge clk or negedge rst_n)
    begin
        voxel_t got;
        voxel_t want;
        if (!rst_n)
            voxel.ready <= 1'b0;
        else
        begin
            if (voxel.valid && voxel.ready)
            begin
                got.voxel_x = voxel.voxel_x;
                got.voxel_y = voxel.voxel_y;
                got.voxel_z = voxel.voxel_z;
                got.entry_distance = voxel.entry_distance;
                got.last_voxel = voxel.last_voxel;
                got.truncated = voxel.truncated;
                voxel_count++;
                if (got.truncated)
                    trunc_count++;
                if (expected_voxels.size() == 0)
                begin
                    $error("unexpected voxel word %p", got);
                    error_count++;
                end
                else
                begin
                    want = expected_voxels.pop_front();
                    if (got.voxel_x !== want.voxel_x)
                    begin
                        $error("voxel_x expected %0d actual %0d", want.voxel_x, got.voxel_x);
                        error_count++;
                    end
                    if (got.voxel_y !== want.voxel_y)
                    begin
                        $error("voxel_y expected %0d actual %0d", want.voxel_y, got.voxel_y);
                        error_count++;
                    end
                    if (got.voxel_z !== want.voxel_z)
                    begin
                        $error("voxel_z expected %0d actual %0d", want.voxel_z, got.voxel_z);
                        error_count++;
                    end
                    if (got.entry_distance !== want.entry_distance)
                    begin
                        $error("entry_distance expected %0d actual %0d",
                               want.entry_distance, got.entry_distance);
                        error_count++;
                    end
                    if (got.last_voxel !== want.last_voxel)
                    begin
                        $error("last_voxel expected %0d actual %0d",
                               want.last_voxel, got.last_voxel);
                        error_count++;
                    end
                    if (got.truncated !== want.truncated)
                    begin
                        $error("truncated expected %0d actual %0d",
                               want.truncated, got.truncated);
                        error_count++;
                    end
                end
            end
            if (hold_sink)
                voxel.ready <= 1'b0;
            else if (voxel_gap > 0)
            begin
                voxel.ready <= 1'b0;
                voxel_gap <= voxel_gap - 1;
            end
            else if (drive_noise && $urandom_range(0, 7) == 0)
            begin
                voxel.ready <= 1'b0;
                voxel_gap <= $urandom_range(0, 18);
            end
            else
                voxel.ready <= 1'b1;
        end
    end

    function automatic ray_t make_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                      logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                                      logic [21:0] len);
        ray_t r;
        r.origin_x = ox;
        r.origin_y = oy;
        r.origin_z = oz;
        r.dir_x = dx;
        r.dir_y = dy;
        r.dir_z = dz;
        r.ray_length = len;
        return r;
    endfunction

    function automatic ray_t random_ray();
        logic [15:0] d[3];
        logic [31:0] o[3];
        logic [21:0] len;
        for (int i = 0; i < 3; i++)
        begin
            case ($urandom_range(0, 5))
                0: d[i] = 16'd0;
                1: d[i] = 16'h8000;
                2: d[i] = 16'h7fff;
                3: d[i] = 16'($urandom_range(0, 3) - 1);
                default: d[i] = 16'($urandom());
            endcase
            case ($urandom_range(0, 4))
                0: o[i] = $urandom();
                1: o[i] = {$urandom_range(0, 1) ? 16'h7fff : 16'h8000, 16'($urandom())};
                2: o[i] = {16'($urandom()), 16'd0};
                default: o[i] = {16'($urandom_range(0, 63)) - 16'd32, 16'($urandom())};
            endcase
        end
        case ($urandom_range(0, 5))
            0: len = 22'd0;
            1: len = 22'd2097152;
            2: len = 22'($urandom_range(0, 22'h3fffff));
            default: len = 22'($urandom_range(0, 22'h80000));
        endcase
        return make_ray(o[0], o[1], o[2], d[0], d[1], d[2], len);
    endfunction

    task automatic wait_drained();
        while (pending_rays.size() != 0 || ray.valid || expected_voxels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.voxel_limit <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        limit_shadow = value;
        cfg.valid <= 1'b0;
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            enqueue_ray(random_ray());
    endtask

    initial
    begin
        error_count = 0;
        ray_count = 0;
        voxel_count = 0;
        trunc_count = 0;
        drive_noise = 0;
        hold_sink = 0;
        hold_source = 0;
        ray_gap = 0;
        voxel_gap = 0;
        limit_shadow = LIMIT_RESET;
        rst_n = 1'b0;
        ray.valid = 1'b0;
        ray.origin_x = '0;
        ray.origin_y = '0;
        ray.origin_z = '0;
        ray.dir_x = '0;
        ray.dir_y = '0;
        ray.dir_z = '0;
        ray.ray_length = '0;
        voxel.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.voxel_limit = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset limit
        enqueue_ray(make_ray(32'h0001_8000, 32'h0002_4000, 32'hffff_0000,
                             16'd0, 16'd0, 16'd0, 22'd2097152));
        enqueue_ray(make_ray(32'h0000_8000, 32'h0, 32'h0,
                             16'h4000, 16'h0, 16'h0, 22'd0));
        enqueue_ray(make_ray(32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                             16'h7fff, 16'h0, 16'h0, 22'd2097152));
        enqueue_ray(make_ray(32'h0, 32'h0, 32'h0,
                             16'h8000, 16'h8000, 16'h8000, 22'd2097152));
        enqueue_ray(make_ray(32'h0, 32'h0000_8000, 32'h0,
                             16'h0, 16'hc000, 16'h0, 22'h30000));
        enqueue_ray(make_ray(32'h7fff_ffff, 32'h8000_0000, 32'h0,
                             16'h1000, 16'hf000, 16'h0, 22'd2097152));
        enqueue_ray(make_ray(32'h0000_4000, 32'h0000_4000, 32'h0000_4000,
                             16'h1000, 16'h1000, 16'h1000, 22'h50000));
        enqueue_ray(make_ray(32'h1234_5678, 32'hedcb_a987, 32'h0000_ffff,
                             16'h0001, 16'hffff, 16'h7fff, 22'h3fffff));
        wait_drained();

        write_limit(7'd1);
        enqueue_ray(make_ray(32'h0, 32'h0, 32'h0,
                             16'h4000, 16'h0, 16'h0, 22'h20000));
        enqueue_ray(make_ray(32'h0, 32'h0, 32'h0,
                             16'h4000, 16'h0, 16'h0, 22'h0));
        wait_drained();
        write_limit(7'd0);
        enqueue_ray(make_ray(32'h0, 32'h0, 32'h0,
                             16'h4000, 16'h0, 16'h0, 22'h20000));
        wait_drained();
        write_limit(7'd127);
        enqueue_ray(make_ray(32'h0, 32'h0, 32'h0,
                             16'h2000, 16'h3000, 16'h1000, 22'd2097152));
        wait_drained();
        write_limit(7'd3);
        enqueue_ray(make_ray(32'h0000_8000, 32'h0, 32'h0,
                             16'h4000, 16'h0, 16'h0, 22'h28000));
        wait_drained();

        // random with idling on both sides
        drive_noise = 1;
        ray_gap = 1;
        write_limit(7'd64);
        queue_random(60);
        wait_drained();
        write_limit(7'd8);
        queue_random(50);
        // long receiver stall while rays keep coming
        hold_sink = 1;
        repeat (400) @(posedge clk);
        hold_sink = 0;
        wait_drained();
        write_limit(7'($urandom_range(2, 63)));
        queue_random(50);
        wait_drained();
        write_limit(7'd64);
        queue_random(40);
        wait_drained();

        // final part with no idling
        drive_noise = 0;
        ray_gap = 0;
        write_limit(7'd16);
        queue_random(50);
        wait_drained();

        $display("%0d rays sent, %0d voxel words checked, %0d truncated walks",
                 ray_count, voxel_count, trunc_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
